@@ hdl/chdec_pkg.sv @@
// Package for the chunked body decoder: item structs, parse phases,
// status codes and the hex digit decoder. No dependencies.
package chdec_pkg;

  localparam int unsigned SizeWidthDef = 32;

  // Result status codes.
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;
  localparam logic [1:0] ST_EARLY = 2'd3;

  // Input operation codes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Characters of the framing.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [3:0] {
    PH_SIZE     = 4'd0,
    PH_SIZE_CR  = 4'd1,
    PH_EXT      = 4'd2,
    PH_EXT_CR   = 4'd3,
    PH_DATA     = 4'd4,
    PH_DATA_CR  = 4'd5,
    PH_DATA_LF  = 4'd6,
    PH_TRAIL    = 4'd7,
    PH_TRAIL_CR = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic [1:0] status;
  } out_item_t;

  // Item held in the input register.
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } in_slot_t;

  // Result of one parse step.
  typedef struct packed {
    logic      vld;
    out_item_t item;
  } res_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low bits 1..6.
      h.value = 4'(4'd9 + c[3:0]);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ hdl/chdec_in_stage.sv @@
// Input register of the chunked body decoder.
// Depends on chdec_pkg.
module chdec_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chdec_pkg::in_item_t in_data,
  input  logic               out_room,
  output chdec_pkg::in_slot_t slot,
  output logic               fire
);
  import chdec_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  assign fire     = vld_r && out_room;
  assign in_ready = !vld_r || fire;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign slot.vld  = vld_r;
  assign slot.item = item_r;

endmodule

@@ hdl/chdec_parser.sv @@
// Parse state machine of the chunked body decoder: phase, size
// accumulator and chunk byte counter. Depends on chdec_pkg.
module chdec_parser #(
  parameter int unsigned SIZE_WIDTH = chdec_pkg::SizeWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chdec_pkg::in_slot_t slot,
  input  logic                fire,
  output chdec_pkg::res_t     res
);
  import chdec_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [SIZE_WIDTH-1:0] size_r, size_nxt;
  logic [SIZE_WIDTH-1:0] left_r, left_nxt;
  logic                  nonempty_r, nonempty_nxt;

  logic [7:0]            c;
  hex_t                  hex;
  logic                  ovf;
  logic [SIZE_WIDTH-1:0] size_shift;

  assign c          = slot.item.rx_byte;
  assign hex        = hex_decode(c);
  assign ovf        = |size_r[SIZE_WIDTH-1 -: 4];
  assign size_shift = {size_r[SIZE_WIDTH-5:0], hex.value};

  always_comb begin
    phase_nxt    = phase_r;
    size_nxt     = size_r;
    left_nxt     = left_r;
    nonempty_nxt = nonempty_r;
    res          = '0;
    if (fire && phase_r != PH_DONE) begin
      if (slot.item.op == OP_CLOSE) begin
        phase_nxt       = PH_DONE;
        res.vld         = 1'b1;
        res.item.status = ST_EARLY;
      end else begin
        unique case (phase_r)
          PH_SIZE, PH_EXT, PH_SIZE_CR, PH_EXT_CR: begin
            priority if ((phase_r == PH_SIZE_CR || phase_r == PH_EXT_CR) && c == CH_LF) begin
              if (size_r == '0) begin
                phase_nxt    = PH_TRAIL;
                nonempty_nxt = 1'b0;
              end else begin
                left_nxt  = size_r;
                phase_nxt = PH_DATA;
              end
              size_nxt = '0;
            end else if (c == CH_CR) begin
              phase_nxt = (phase_r == PH_SIZE || phase_r == PH_SIZE_CR) ? PH_SIZE_CR
                                                                         : PH_EXT_CR;
            end else if (phase_r == PH_EXT || phase_r == PH_EXT_CR) begin
              phase_nxt = PH_EXT;
            end else if (c == CH_SEMI) begin
              phase_nxt = PH_EXT;
            end else begin
              phase_nxt = PH_SIZE;
              if (hex.is_hex) begin
                if (ovf) begin
                  phase_nxt       = PH_DONE;
                  res.vld         = 1'b1;
                  res.item.status = ST_FRAME;
                end else begin
                  size_nxt = size_shift;
                end
              end
            end
          end
          PH_DATA: begin
            left_nxt           = left_r - SIZE_WIDTH'(1);
            if (left_r == SIZE_WIDTH'(1)) begin
              phase_nxt = PH_DATA_CR;
            end
            res.vld            = 1'b1;
            res.item.body_byte = c;
            res.item.status    = ST_DATA;
          end
          PH_DATA_CR: begin
            if (c == CH_CR) begin
              phase_nxt = PH_DATA_LF;
            end else begin
              phase_nxt       = PH_DONE;
              res.vld         = 1'b1;
              res.item.status = ST_FRAME;
            end
          end
          PH_DATA_LF: begin
            if (c == CH_LF) begin
              phase_nxt = PH_SIZE;
              size_nxt  = '0;
            end else begin
              phase_nxt       = PH_DONE;
              res.vld         = 1'b1;
              res.item.status = ST_FRAME;
            end
          end
          PH_TRAIL: begin
            if (c == CH_CR) begin
              phase_nxt = PH_TRAIL_CR;
            end else begin
              nonempty_nxt = 1'b1;
            end
          end
          PH_TRAIL_CR: begin
            if (c == CH_LF) begin
              if (!nonempty_r) begin
                phase_nxt       = PH_DONE;
                res.vld         = 1'b1;
                res.item.status = ST_DONE;
              end else begin
                nonempty_nxt = 1'b0;
                phase_nxt    = PH_TRAIL;
              end
            end else begin
              nonempty_nxt = 1'b1;
              if (c != CH_CR) begin
                phase_nxt = PH_TRAIL;
              end
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIZE;
      size_r     <= '0;
      left_r     <= '0;
      nonempty_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      size_r     <= size_nxt;
      left_r     <= left_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

@@ hdl/chdec_out_stage.sv @@
// Result register of the chunked body decoder.
// Depends on chdec_pkg.
module chdec_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  chdec_pkg::res_t     res,
  input  logic                fire,
  output logic                out_room,
  output logic                out_valid,
  input  logic                out_ready,
  output chdec_pkg::out_item_t out_data
);
  import chdec_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t item_r;

  assign out_room = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (fire && res.vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.vld) begin
      item_r <= res.item;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = item_r;

endmodule

@@ hdl/http_chunked_body_decoder_core.sv @@
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on chdec_pkg, chdec_in_stage, chdec_parser and chdec_out_stage.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_data    | op (byte or close), rx_byte
//   result  | out_valid, out_ready, out_data | body_byte, status
//
// Each item is registered on entry and goes through the parse state machine
// once the result register has room; a result that it causes is written into
// the result register at the end of that same cycle. The block sustains one
// item per cycle while the result side is not stalled; the phase, size
// accumulator and chunk counter are all updated for each item as it moves on.
// Reset is synchronous on rst_n and returns the parser to the start
// of a size line. When out_ready is low with a result waiting, one more item
// may wait in the input register; the input stalls only then.
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_WIDTH = chdec_pkg::SizeWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chdec_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chdec_pkg::out_item_t out_data
);
  import chdec_pkg::*;

  in_slot_t slot;
  res_t     res;
  logic     fire;
  logic     out_room;

  // Input register: an item moves on when the result register has room.
  chdec_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_room (out_room),
    .slot     (slot),
    .fire     (fire)
  );

  // Parser: advances its state once for every item that moves on and
  // produces at most one result for it.
  chdec_parser #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .slot  (slot),
    .fire  (fire),
    .res   (res)
  );

  // Result register: holds a result until the consumer takes it.
  chdec_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .fire      (fire),
    .out_room  (out_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/chdec_checker.sv @@
// Port-level checks for the chunked body decoder and their bind.
// Depends on chdec_pkg and http_chunked_body_decoder_core.
module chdec_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input chdec_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input chdec_pkg::out_item_t out_data
);
  import chdec_pkg::*;

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // With the consumer ready the block never stalls its input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is ready");

  // Only data results carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DATA |-> out_data.body_byte == 8'd0)
    else $error("status result carries a nonzero byte");

  // Once the body has ended no further result follows.
  a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.status != ST_DATA |=> !out_valid)
    else $error("result after end of body");

endmodule

bind http_chunked_body_decoder_core chdec_checker u_chdec_checker (.*);

@@ tb/tb_http_chunked_body_decoder_core.sv @@
// Self-checking testbench for http_chunked_body_decoder_core: drives chunked byte streams
// on the input channel and compares every result item with an in-bench decoder model.
// Depends on chdec_pkg and the decoder RTL; needs no files or arguments.
module tb_http_chunked_body_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import chdec_pkg::*;

  localparam int SW = chdec_pkg::SizeWidthDef;
  // Generous bound on the whole run: every item may see the longest sender gap
  // and the longest receiver stall, and the body is only about 1200 items long.
  localparam int unsigned CYCLE_LIMIT = 600000;

  // How the single body of the run is brought to an end.
  typedef enum int {
    END_COMPLETE,
    END_BAD_CR,
    END_BAD_LF,
    END_OVERFLOW,
    END_CLOSED
  } end_kind_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  http_chunked_body_decoder_core #(
    .SIZE_WIDTH(SW)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Decoder state as the bench tracks it. It is advanced once per accepted
  // item, so the stimulus can also read it to build well-formed chunks.
  phase_t       dec_phase     = PH_SIZE;
  logic [SW-1:0] dec_size     = '0;
  logic [SW-1:0] dec_left     = '0;
  logic         dec_line_full = 1'b0;
  logic         dec_finished  = 1'b0;

  // Body bytes and status items the decoder still owes us, oldest first.
  out_item_t    decoded_q[$];
  out_item_t    want;

  int unsigned  items_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           idle_on = 1'b1;
  int unsigned  stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Value of a hex digit of either case; returns 0 when the byte is not one.
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One content character of a size line. Returns 1 when a digit would push
  // set bits out of the top of the size accumulator.
  function automatic bit size_char(input logic [7:0] c);
    logic [3:0] v;
    if (c == CH_SEMI) begin
      dec_phase = PH_EXT;
      return 1'b0;
    end
    dec_phase = PH_SIZE;
    if (!hex_nibble(c, v)) return 1'b0;
    if (dec_size[SW-1 -: 4] != 4'd0) return 1'b1;
    dec_size = {dec_size[SW-5:0], v};
    return 1'b0;
  endfunction

  // The body is over; every later item is ignored.
  function automatic bit body_ends(output out_item_t res, input logic [1:0] st);
    dec_finished   = 1'b1;
    dec_phase      = PH_DONE;
    res.body_byte  = 8'd0;
    res.status     = st;
    return 1'b1;
  endfunction

  // Advances the model by one item; returns 1 when the item causes a result.
  function automatic bit chunk_decode(input in_item_t it, output out_item_t res);
    logic [7:0] c;
    c   = it.rx_byte;
    res = '0;
    if (dec_finished) return 1'b0;
    if (it.op == OP_CLOSE) return body_ends(res, ST_EARLY);
    case (dec_phase)
      PH_SIZE, PH_EXT: begin
        if (c == CH_CR) begin
          if (dec_phase == PH_SIZE) dec_phase = PH_SIZE_CR;
          else dec_phase = PH_EXT_CR;
          return 1'b0;
        end
        if (dec_phase == PH_EXT) return 1'b0;
        if (size_char(c)) return body_ends(res, ST_FRAME);
        return 1'b0;
      end
      PH_SIZE_CR, PH_EXT_CR: begin
        if (c == CH_LF) begin
          if (dec_size == '0) begin
            dec_phase     = PH_TRAIL;
            dec_line_full = 1'b0;
          end else begin
            dec_left  = dec_size;
            dec_phase = PH_DATA;
          end
          dec_size = '0;
          return 1'b0;
        end
        // A CR that is not followed by LF is just another character.
        if (c == CH_CR) return 1'b0;
        if (dec_phase == PH_EXT_CR) begin
          dec_phase = PH_EXT;
          return 1'b0;
        end
        if (size_char(c)) return body_ends(res, ST_FRAME);
        return 1'b0;
      end
      PH_DATA: begin
        dec_left = dec_left - SW'(1);
        if (dec_left == '0) dec_phase = PH_DATA_CR;
        res.body_byte = c;
        res.status    = ST_DATA;
        return 1'b1;
      end
      PH_DATA_CR: begin
        if (c != CH_CR) return body_ends(res, ST_FRAME);
        dec_phase = PH_DATA_LF;
        return 1'b0;
      end
      PH_DATA_LF: begin
        if (c != CH_LF) return body_ends(res, ST_FRAME);
        dec_phase = PH_SIZE;
        dec_size  = '0;
        return 1'b0;
      end
      PH_TRAIL: begin
        if (c == CH_CR) dec_phase = PH_TRAIL_CR;
        else dec_line_full = 1'b1;
        return 1'b0;
      end
      PH_TRAIL_CR: begin
        if (c == CH_LF) begin
          // An empty trailer line closes the body.
          if (!dec_line_full) return body_ends(res, ST_DONE);
          dec_line_full = 1'b0;
          dec_phase     = PH_TRAIL;
          return 1'b0;
        end
        dec_line_full = 1'b1;
        if (c != CH_CR) dec_phase = PH_TRAIL;
        return 1'b0;
      end
      default: begin
        dec_finished = 1'b1;
        dec_phase    = PH_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping
  // ---------------------------------------------------------------------------

  // Idle length for either side: mostly none, sometimes a few cycles and now
  // and then a long stretch. With idle_on clear both sides run flat out.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: ready drops for random stretches, changed only at falling edges.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        stall_left = pick_gap();
        out_ready  = (stall_left == 0);
        if (stall_left > 0) stall_left = stall_left - 1;
      end
    end
  end

  // Every accepted result is checked against the oldest item still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result item: status %0d body_byte %02h",
               out_data.status, out_data.body_byte);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.body_byte !== want.body_byte) begin
          $error("body_byte: expected %02h, got %02h", want.body_byte, out_data.body_byte);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and holds it until it is taken. Called
  // and returning at a falling edge; the model is advanced at the accepting edge.
  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned gap;
    out_item_t   res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.op      = op;
    in_data.rx_byte = b;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!dec_finished) items_sent++;
    if (chunk_decode(in_data, res)) decoded_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hex digit character, upper or lower case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1)) return 8'(8'h41 + v - 4'd10);
    return 8'(8'h61 + v - 4'd10);
  endfunction

  // A byte that a size line skips and that cannot end the line.
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    logic [3:0] v;
    do b = 8'($urandom);
    while (hex_nibble(b, v) || b == CH_SEMI || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Junk in a size line: a skipped character, or a lone CR and one.
  task automatic send_noise();
    if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
    send_byte(pick_junk());
  endtask

  // Size line for a chunk of 1..255 bytes, with random leading zeros, digit
  // case, optional junk and an optional extension, ended by CR LF.
  task automatic send_size_line(input int unsigned size, input bit noisy);
    int unsigned zeros;
    int          ndig;
    logic [7:0]  b;
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 1);
    ndig  = (size < 16) ? 1 : 2;
    repeat (zeros) send_byte(8'h30);
    for (int i = ndig - 1; i >= 0; i--) begin
      if (noisy && $urandom_range(0, 3) == 0) send_noise();
      send_byte(hex_char(4'(size >> (4 * i))));
    end
    if (noisy && $urandom_range(0, 1)) send_noise();
    if ($urandom_range(0, 9) < 3) begin
      // Extension text is ignored up to the CR LF; the random bytes here exclude CR.
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom); while (b == CH_CR);
        send_byte(b);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_CR);
        send_byte(pick_junk());
      end
    end
    send_crlf();
  endtask

  // Random payload for the chunk that the size line just opened.
  task automatic send_chunk_data();
    while (dec_phase == PH_DATA) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-written chunks: byte extremes, a size followed by an extension
  // holding a lone CR, junk and a lone CR ahead of the size digit, and CR and
  // LF passed through as data.
  task automatic test_directed_chunks();
    send_text("1");
    send_crlf();
    send_byte(8'hFF);
    send_crlf();

    send_text("02;");
    send_byte(CH_CR);
    send_text(";");
    send_crlf();
    send_byte(8'h00);
    send_byte(CH_CR);
    send_crlf();

    send_text("x");
    send_byte(CH_CR);
    send_text("1");
    send_crlf();
    send_byte(CH_LF);
    send_crlf();
  endtask

  // Well-formed chunks with random content until the item count reaches the
  // target. Most chunks are short; a few are up to 255 bytes long.
  task automatic test_random_chunks(input int unsigned target);
    int unsigned size;
    while (items_sent < target) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 255) : $urandom_range(1, 16);
      send_size_line(size, $urandom_range(0, 2) == 0);
      send_chunk_data();
      send_crlf();
    end
  endtask

  // The sender holds off until every owed result has been taken.
  task automatic test_hold_until_drained();
    in_valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat ($urandom_range(2, 10)) @(negedge clk);
  endtask

  // Reset is applied only once, so a run holds a single body and the way it
  // ends is drawn at random: a normal finish through trailer lines, a broken
  // CR LF after a chunk, a size too wide for the counter, or a closed
  // connection. Items sent afterwards must be ignored.
  task automatic test_body_end();
    end_kind_t kind;
    logic [7:0] b;
    kind = end_kind_t'($urandom_range(0, 4));
    case (kind)
      END_COMPLETE: begin
        // A last-chunk line of "0", or simply an empty line.
        if ($urandom_range(0, 1)) begin
          send_text("0");
          if ($urandom_range(0, 1)) send_text(";last");
        end
        send_crlf();
        repeat ($urandom_range(0, 3)) begin
          send_text("X-T: v");
          if ($urandom_range(0, 1)) begin
            send_byte(CH_CR);
            send_text("q");
          end
          if ($urandom_range(0, 1)) send_byte(CH_CR);
          send_crlf();
        end
        send_crlf();
      end
      END_BAD_CR: begin
        send_size_line($urandom_range(1, 4), 1'b0);
        send_chunk_data();
        do b = 8'($urandom); while (b == CH_CR);
        send_byte(b);
      end
      END_BAD_LF: begin
        send_size_line($urandom_range(1, 4), 1'b0);
        send_chunk_data();
        send_byte(CH_CR);
        do b = 8'($urandom); while (b == CH_LF);
        send_byte(b);
      end
      END_OVERFLOW: begin
        // A nonzero lead digit fills the top nibble after eight digits,
        // so the ninth one cannot fit.
        send_byte(hex_char(4'($urandom_range(1, 15))));
        repeat (8) send_byte(hex_char(4'($urandom)));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: send_text("1");
          1: begin
            send_size_line(4, 1'b0);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
          end
          2: begin
            send_text("0");
            send_crlf();
            send_text("X");
          end
          default: ;
        endcase
        send_item(OP_CLOSE, 8'($urandom));
      end
    endcase
    repeat ($urandom_range(2, 5)) send_byte(8'($urandom));
    send_item(OP_CLOSE, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_chunks();
    test_random_chunks(450);
    test_hold_until_drained();
    // A stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_chunks(650);
    idle_on = 1'b1;
    test_random_chunks(1150);
    test_body_end();
    in_valid = 1'b0;

    // Let the last results drain, then allow a few cycles for anything stray.
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
